>>> hdl/utfn_pkg.sv
package utfn_pkg;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_LEAD  = 2'd1,
        ERR_CONT  = 2'd2,
        ERR_TRUNC = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        err_t       error_code;
        logic       stream_end;
    } out_t;

    // Results that one request pushes into the output queue.
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

    localparam logic [7:0] CHAR_U  = 8'h75;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

endpackage

>>> hdl/utfn_decode.sv
module utfn_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  utfn_pkg::in_t   item,
    input  logic            advance,
    input  logic            cr_to_lf,
    output utfn_pkg::push_t push
);

    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [20:0] acc_reg;
    logic [20:0] acc_next;

    logic [7:0]     b;
    logic [20:0]    acc_shift;
    utfn_pkg::out_t res_u;
    utfn_pkg::out_t res_err;

    assign b         = item.text_byte;
    assign acc_shift = {acc_reg[14:0], b[5:0]};

    always_comb
    begin
        res_u            = '0;
        res_u.out_char   = utfn_pkg::CHAR_U;
        res_u.error_code = utfn_pkg::ERR_OK;
        res_err          = '0;
        push             = '0;
        pend_next        = pend_reg;
        acc_next         = acc_reg;

        if (pend_reg != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                acc_next  = acc_shift;
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    push.first  = res_u;
                    push.second = res_u;
                    push.count  = (acc_shift[20:16] != 5'd0) ? 2'd2 : 2'd1;
                    acc_next    = '0;
                end
            end
            else
            begin
                res_err.error_code = utfn_pkg::ERR_CONT;
                push.first         = res_err;
                push.count         = 2'd1;
                pend_next          = 2'd0;
                acc_next           = '0;
            end
        end
        else if (b[7])
        begin
            case (b[6:3])
                4'b1111:
                begin
                    res_err.error_code = utfn_pkg::ERR_LEAD;
                    push.first         = res_err;
                    push.count         = 2'd1;
                end
                4'b1110:
                begin
                    pend_next = 2'd3;
                    acc_next  = {18'd0, b[2:0]};
                end
                4'b1100, 4'b1101:
                begin
                    pend_next = 2'd2;
                    acc_next  = {17'd0, b[3:0]};
                end
                4'b1000, 4'b1001, 4'b1010, 4'b1011:
                begin
                    pend_next = 2'd1;
                    acc_next  = {16'd0, b[4:0]};
                end
                default:
                begin
                    push.first = res_u;
                    push.count = 2'd1;
                end
            endcase
        end
        else
        begin
            push.first.error_code = utfn_pkg::ERR_OK;
            push.first.out_char   = (b == utfn_pkg::CHAR_CR && cr_to_lf) ?
                                    utfn_pkg::CHAR_LF : b;
            push.count            = 2'd1;
        end

        if (item.final_byte)
        begin
            if (pend_next != 2'd0)
            begin
                res_err.error_code = utfn_pkg::ERR_TRUNC;
                push.first         = res_err;
                push.count         = 2'd1;
            end
            pend_next = 2'd0;
            acc_next  = '0;
        end

        if (push.count == 2'd2)
        begin
            push.second.run_end    = 1'b1;
            push.second.stream_end = item.final_byte;
        end
        else
        begin
            push.first.run_end    = 1'b1;
            push.first.stream_end = item.final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            acc_reg  <= '0;
        end
        else if (advance)
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

>>> hdl/utfn_outq.sv
module utfn_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  utfn_pkg::push_t push,
    output logic            room,
    output logic            dst_valid,
    input  logic            dst_ready,
    output utfn_pkg::out_t  dst_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    utfn_pkg::out_t mem_reg [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          pop;

    assign dst_valid   = (count_reg != '0);
    assign dst_data    = mem_reg[rd_ptr_reg];
    assign pop         = dst_valid && dst_ready;
    assign room        = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_next = wr_ptr_reg + AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/utf8_neutralizer.sv
// Channel   Direction  Handshake              Payload
// src       in         src_valid/src_ready    utfn_pkg::in_t  (text_byte, final_byte)
// dst       out        dst_valid/dst_ready    utfn_pkg::out_t (out_char, run_end,
//                                                               error_code, stream_end)
// apb       in         psel/penable/pwrite    cr_to_lf at byte address 0
//
// A request is registered on entry and decoded from that register, once the queue has
// room, into zero, one or two results, which go into a four-entry result queue.
// One request per cycle is taken while the queue holds at most two results; a
// request that yields two results fills two queue entries, read out one at a time.
// Reset clears the sequence state, the queue and sets cr_to_lf to 1.
// A stalled output fills the queue and then holds src_ready low.
module utf8_neutralizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_ready,
    input  utfn_pkg::in_t  src_data,
    output logic           dst_valid,
    input  logic           dst_ready,
    output utfn_pkg::out_t dst_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic            cr_to_lf_reg;
    logic            s1_valid_reg;
    utfn_pkg::in_t   s1_data_reg;
    logic            s1_adv;
    logic            room;
    utfn_pkg::push_t dec_push;
    utfn_pkg::push_t q_push;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, cr_to_lf_reg} : 32'd0;
    assign s1_adv    = s1_valid_reg && room;
    assign src_ready = !s1_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_to_lf_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            cr_to_lf_reg <= pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            s1_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
        begin
            s1_data_reg <= src_data;
        end
    end

    utfn_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (s1_data_reg),
        .advance  (s1_adv),
        .cr_to_lf (cr_to_lf_reg),
        .push     (dec_push)
    );

    always_comb
    begin
        q_push = dec_push;
        if (!s1_adv)
        begin
            q_push.count = 2'd0;
        end
    end

    utfn_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .room      (room),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    // Every final byte produces at least one result.
    a_final_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_data_reg.final_byte |-> dec_push.count != 2'd0)
        else $error("final byte produced no result");

    // Error results carry a zero character.
    a_error_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.error_code != utfn_pkg::ERR_OK |-> dst_data.out_char == 8'd0)
        else $error("error result with nonzero character");

    // The end of the stream is also the end of that byte's results.
    a_stream_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.stream_end |-> dst_data.run_end)
        else $error("stream end without run end");

    // A held input stage keeps its request until the decoder takes it.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input stage lost a request");

endmodule
